// ----- rtl/drf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the dithered rectangle fill block: screen geometry, widths,
// register indexes and the structs passed between its modules. No dependencies.
package drf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_DEPTH   = 1024;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam int NUM_PAGES     = (SCREEN_HEIGHT + 7) / 8;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int IDX_RAW_W     = $clog2(SCREEN_WIDTH * NUM_PAGES);
  localparam int IDX_W         = (IDX_RAW_W > STORE_AW) ? IDX_RAW_W : STORE_AW;
  localparam int CLIP_W        = 18;
  localparam int PAT_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int COORD_W       = 16;
  localparam int READ_IDX_W    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_EVEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ODD  = 2'd1;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [2:0] LAST_ROW  = 3'd7;

  typedef struct packed {
    logic             empty;
    logic [COL_W-1:0] col_first;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
  } clip_t;

  typedef struct packed {
    logic                rd;
    logic                wr;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          wdata;
  } store_req_t;

endpackage

// ----- rtl/drf_clip.sv -----
`timescale 1ns / 1ps
// Clips a signed rectangle to the screen and reports its first and last
// column and row. Depends on drf_pkg.
module drf_clip (
  input  logic signed [drf_pkg::COORD_W-1:0] left,
  input  logic signed [drf_pkg::COORD_W-1:0] top,
  input  logic        [7:0]                  width_px,
  input  logic signed [7:0]                  height_px,
  output drf_pkg::clip_t                     clip
);
  import drf_pkg::*;

  localparam logic signed [CLIP_W-1:0] SW_S = CLIP_W'(SCREEN_WIDTH);
  localparam logic signed [CLIP_W-1:0] SH_S = CLIP_W'(SCREEN_HEIGHT);
  localparam logic signed [CLIP_W-1:0] ONE_S = CLIP_W'(1);

  logic signed [CLIP_W-1:0] x_lo, y_lo, x_end, y_end;
  logic signed [CLIP_W-1:0] x_first, y_first, x_stop, y_stop, x_last, y_last;

  always_comb begin
    x_lo    = CLIP_W'(left);
    y_lo    = CLIP_W'(top);
    x_end   = x_lo + CLIP_W'(width_px);
    y_end   = y_lo + CLIP_W'(height_px);
    x_first = x_lo[CLIP_W-1] ? '0 : x_lo;
    y_first = y_lo[CLIP_W-1] ? '0 : y_lo;
    x_stop  = (x_end > SW_S) ? SW_S : x_end;
    y_stop  = (y_end > SH_S) ? SH_S : y_end;
    x_last  = x_stop - ONE_S;
    y_last  = y_stop - ONE_S;
    clip.empty     = (x_stop <= x_first) || (y_stop <= y_first);
    clip.col_first = x_first[COL_W-1:0];
    clip.col_last  = x_last[COL_W-1:0];
    clip.row_first = y_first[ROW_W-1:0];
    clip.row_last  = y_last[ROW_W-1:0];
  end

endmodule

// ----- rtl/drf_store.sv -----
`timescale 1ns / 1ps
// Framebuffer byte store with a registered read port and a clearing pass
// after reset. Depends on drf_pkg.
module drf_store (
  input  logic                clk,
  input  logic                rst_n,
  input  drf_pkg::store_req_t req,
  output logic [7:0]          rd_data,
  output logic                ready
);
  import drf_pkg::*;

  logic [7:0]          mem [STORE_DEPTH];
  logic [7:0]          rd_data_r;
  logic                clr_busy_r, clr_busy_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                we;
  logic [STORE_AW-1:0] wa;
  logic [7:0]          wd;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
    we = clr_busy_r ? 1'b1 : req.wr;
    wa = clr_busy_r ? clr_cnt_r : req.addr;
    wd = clr_busy_r ? 8'h00 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

// ----- rtl/dithered_rect_fill.sv -----
`timescale 1ns / 1ps
// Dithered rectangle fill into a paged monochrome framebuffer (top level).
// Depends on drf_pkg, drf_clip and drf_store.
//
// The input channel takes one request at a time: a fill (kind 0) with a
// signed rectangle and a dither level, or a read (kind 1) of one stored byte.
// Every request gives exactly one result on the output channel: read_data for
// a read, drew for a fill. The configuration channel writes the two 64-bit
// pattern registers and is always ready.
// A read passes through a store read step and then the result step. A fill
// first clips the rectangle and then spends a read step and a write step on
// each covered byte, through the single store port; an empty fill goes
// straight from clipping to the result step. The store port is what sets
// the per-byte cost.
// After reset a clearing pass zeroes all 1024 bytes of the store; no request is
// accepted during it, while configuration writes are taken as usual.
// The result sits in an output register. A request can be accepted while the
// previous result still waits; if the receiver stalls, the new request waits
// at its final step until the output register is free.
module dithered_rect_fill (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic signed [drf_pkg::COORD_W-1:0]   in_left,
  input  logic signed [drf_pkg::COORD_W-1:0]   in_top,
  input  logic        [7:0]                    in_width_px,
  input  logic signed [7:0]                    in_height_px,
  input  logic        [2:0]                    in_level,
  input  logic        [drf_pkg::READ_IDX_W-1:0] in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [7:0]                    out_read_data,
  output logic                                 out_drew,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [drf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [drf_pkg::PAT_W-1:0]     cfg_data
);
  import drf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLIP = 6'b000010,
    S_RD   = 6'b000100,
    S_WR   = 6'b001000,
    S_DONE = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      kind_r, kind_nxt;
  logic [2:0]                level_r, level_nxt;
  logic signed [COORD_W-1:0] left_r, left_nxt, top_r, top_nxt;
  logic [7:0]                width_r, width_nxt;
  logic signed [7:0]         height_r, height_nxt;
  logic [IDX_W-1:0]          base_r, base_nxt;
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [ROW_W-1:0]          page_r, page_nxt;
  clip_t                     clip_r, clip_nxt;
  logic                      drew_r, drew_nxt;
  logic [PAT_W-1:0]          pat_even_r, pat_even_nxt, pat_odd_r, pat_odd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_read_data_r, out_read_data_nxt;
  logic                      out_drew_r, out_drew_nxt;

  clip_t            clip;
  store_req_t       store_req;
  logic [7:0]       store_rd_data;
  logic             store_ready;
  logic [IDX_W-1:0] idx;
  logic             idx_ok;
  logic [ROW_W-1:0] page_first, page_last, clip_page;
  logic [2:0]       row_lo, row_hi;
  logic [7:0]       mask, pattern;
  logic             in_fire, out_free;

  drf_clip u_clip (
    .left      (left_r),
    .top       (top_r),
    .width_px  (width_r),
    .height_px (height_r),
    .clip      (clip)
  );

  drf_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (store_rd_data),
    .ready   (store_ready)
  );

  always_comb begin
    in_fire    = in_valid && in_ready;
    out_free   = !out_valid_r || out_ready;
    idx        = base_r + IDX_W'(col_r);
    idx_ok     = 32'(idx) < STORE_DEPTH;
    page_first = clip_r.row_first >> 3;
    page_last  = clip_r.row_last >> 3;
    clip_page  = clip.row_first >> 3;
    row_lo     = (page_r == page_first) ? clip_r.row_first[2:0] : 3'd0;
    row_hi     = (page_r == page_last) ? clip_r.row_last[2:0] : LAST_ROW;
    mask       = (BYTE_ONES << row_lo) & (BYTE_ONES >> (LAST_ROW - row_hi));
    pattern    = col_r[0] ? pat_odd_r[{level_r, 3'b000} +: 8]
                          : pat_even_r[{level_r, 3'b000} +: 8];

    store_req.rd    = (state_r == S_RD);
    store_req.wr    = (state_r == S_WR) && idx_ok;
    store_req.addr  = idx[STORE_AW-1:0];
    store_req.wdata = store_rd_data | (pattern & mask);

    pat_even_nxt = pat_even_r;
    pat_odd_nxt  = pat_odd_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PATTERN_EVEN) begin
        pat_even_nxt = cfg_data;
      end
      if (cfg_index == CFG_PATTERN_ODD) begin
        pat_odd_nxt = cfg_data;
      end
    end

    state_nxt         = state_r;
    kind_nxt          = kind_r;
    level_nxt         = level_r;
    left_nxt          = left_r;
    top_nxt           = top_r;
    width_nxt         = width_r;
    height_nxt        = height_r;
    base_nxt          = base_r;
    col_nxt           = col_r;
    page_nxt          = page_r;
    clip_nxt          = clip_r;
    drew_nxt          = drew_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_read_data_nxt = out_read_data_r;
    out_drew_nxt      = out_drew_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_kind;
          level_nxt  = in_level;
          left_nxt   = in_left;
          top_nxt    = in_top;
          width_nxt  = in_width_px;
          height_nxt = in_height_px;
          drew_nxt   = 1'b0;
          if (in_kind == KIND_READ) begin
            base_nxt  = IDX_W'(in_read_index);
            col_nxt   = '0;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_CLIP;
          end
        end
      end
      S_CLIP: begin
        clip_nxt = clip;
        if (clip.empty) begin
          state_nxt = S_DONE;
        end else begin
          drew_nxt  = 1'b1;
          col_nxt   = clip.col_first;
          page_nxt  = clip_page;
          base_nxt  = IDX_W'(32'(clip_page) * SCREEN_WIDTH);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = (kind_r == KIND_READ) ? S_DONE : S_WR;
      end
      S_WR: begin
        if (col_r == clip_r.col_last) begin
          if (page_r == page_last) begin
            state_nxt = S_DONE;
          end else begin
            page_nxt  = page_r + 1'b1;
            col_nxt   = clip_r.col_first;
            base_nxt  = base_r + IDX_W'(SCREEN_WIDTH);
            state_nxt = S_RD;
          end
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DONE, S_HOLD: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_read_data_nxt = (kind_r == KIND_READ) ? store_rd_data : 8'h00;
          out_drew_nxt      = (kind_r == KIND_READ) ? 1'b0 : drew_r;
          state_nxt         = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pat_even_r  <= '0;
      pat_odd_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pat_even_r  <= pat_even_nxt;
      pat_odd_r   <= pat_odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    level_r         <= level_nxt;
    left_r          <= left_nxt;
    top_r           <= top_nxt;
    width_r         <= width_nxt;
    height_r        <= height_nxt;
    base_r          <= base_nxt;
    col_r           <= col_nxt;
    page_r          <= page_nxt;
    clip_r          <= clip_nxt;
    drew_r          <= drew_nxt;
    out_read_data_r <= out_read_data_nxt;
    out_drew_r      <= out_drew_nxt;
  end

  assign in_ready      = (state_r == S_IDLE) && store_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_drew      = out_drew_r;

endmodule

// ----- rtl/drf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for dithered_rect_fill and the bind that attaches them.
// Depends on the port names of dithered_rect_fill.
module drf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_drew,
  input logic       cfg_ready
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_drew))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drew |-> out_read_data == 8'h00)
    else $error("fill result carries read data");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready && cfg_ready)
    else $error("request port open during the clearing pass");

endmodule

bind dithered_rect_fill drf_checker u_drf_checker (.*);
